>>> hw/rtl/tsas_pkg.sv
package tsas_pkg;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INIT    = 3'd1;
    localparam logic [2:0] ST_PARAM   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_BUS     = 3'd4;

    // Phase codes
    localparam logic [2:0] PH_UNINIT   = 3'd0;
    localparam logic [2:0] PH_IDLE     = 3'd1;
    localparam logic [2:0] PH_READ     = 3'd2;
    localparam logic [2:0] PH_VALIDATE = 3'd3;
    localparam logic [2:0] PH_FAULT    = 3'd4;

    // Command codes
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_RECOVER = 2'd1;
    localparam logic [1:0] CMD_INIT    = 2'd2;

    // Bus result codes
    localparam logic [1:0] BUS_OK      = 2'd0;
    localparam logic [1:0] BUS_TIMEOUT = 2'd1;

    // Temperature usability codes
    localparam logic [1:0] CHK_USABLE  = 2'd0;
    localparam logic [1:0] CHK_INVALID = 2'd1;
    localparam logic [1:0] CHK_STALE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DIVIDER   = 2'd0;
    localparam logic [1:0] CFG_MAX_FAILS = 2'd1;
    localparam logic [1:0] CFG_STALE     = 2'd2;
    localparam logic [1:0] CFG_ADDRESS   = 2'd3;

    // Register reset values and limits
    localparam logic [15:0] DIVIDER_RST   = 16'd10;
    localparam logic [7:0]  MAX_FAILS_RST = 8'd3;
    localparam logic [15:0] STALE_RST     = 16'd50;
    localparam logic [6:0]  ADDRESS_RST   = 7'd24;
    localparam logic [6:0]  ADDR_LOW      = 7'd24;
    localparam logic [6:0]  ADDR_HIGH     = 7'd31;

    localparam logic signed [15:0] INVALID_TEMP = 16'sh8000;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  bus_status;
        logic [15:0] raw_word;
    } req_t;

    typedef struct packed {
        logic               in_fault;
        logic [2:0]         recorded_status;
        logic [2:0]         latched_cause;
        logic [15:0]        total_faults;
        logic [15:0]        age;
        logic [1:0]         temperature_check;
        logic signed [15:0] temperature_tenths;
        logic               read_taken;
        logic [2:0]         status;
    } result_t;

    // Map a bus result to a status code; codes two and three count as a bus error
    function automatic logic [2:0] bus_to_code(input logic [1:0] bus);
        logic [2:0] code;
        if (bus == BUS_OK)
        begin
            code = ST_OK;
        end
        else if (bus == BUS_TIMEOUT)
        begin
            code = ST_TIMEOUT;
        end
        else
        begin
            code = ST_BUS;
        end
        return code;
    endfunction

    // Signed Q4 reading to tenths of a degree, rounding half away from zero
    function automatic logic signed [15:0] convert_tenths(input logic [15:0] raw);
        logic [12:0] t13;
        logic [12:0] mag;
        logic [15:0] scaled;
        logic [11:0] quot;
        logic signed [15:0] tenths;
        t13 = raw[12:0];
        if (t13[12])
        begin
            mag = 13'(14'h2000 - {1'b0, t13});
        end
        else
        begin
            mag = t13;
        end
        scaled = 16'(mag) * 16'd10 + 16'd8;
        quot   = scaled[15:4];
        if (t13[12])
        begin
            tenths = 16'sd0 - $signed({4'b0000, quot});
        end
        else
        begin
            tenths = $signed({4'b0000, quot});
        end
        return tenths;
    endfunction

endpackage

>>> hw/rtl/temp_sensor_acquisition_supervisor_top.sv
// Channel   Direction  Payload
// s_axis    in         command, bus_status, raw_word (one request per command)
// m_axis    out        status, flags, cached temperature, age, diagnostics
// cfg       in         register writes: divider, failure limit, stale limit, address
//
// One request per clock sustained while m_tready holds up. A request is registered in
// the input register on entry; its state update and result are formed from it and loaded
// into the result register, which drives m_axis.
// Reset clears the phase machine, counters and handshake flags; registers return to
// their defaults. A stalled result holds in the output register; the input register
// keeps taking requests until it too is full.
module temp_sensor_acquisition_supervisor_top
    import tsas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // command[1:0], bus_status[3:2], raw_word[19:4], zero fill[23:20]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[2:0], read_taken[3], temperature_tenths[19:4], temperature_check[21:20],
    // age[37:22], total_faults[53:38], latched_cause[56:54], recorded_status[59:57],
    // in_fault[60], zero fill[63:61]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    // Configuration registers
    logic [15:0] divider_reg;
    logic [7:0]  max_fails_reg;
    logic [15:0] stale_reg;
    logic [6:0]  address_reg;

    // Pipeline registers
    logic    in_valid_reg;
    req_t    in_req_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t out_res_next;

    // Supervisor state
    logic [2:0]         phase_reg, phase_next;
    logic [15:0]        tick_reg, tick_next;
    logic signed [15:0] cached_reg, cached_next;
    logic [15:0]        age_reg, age_next;
    logic [15:0]        held_reg, held_next;
    logic [2:0]         last_reg, last_next;
    logic [2:0]         cause_reg, cause_next;
    logic [15:0]        total_reg, total_next;
    logic [7:0]         row_reg, row_next;

    logic        out_load;
    logic        advance;
    logic [2:0]  status;
    logic        taken;
    logic [1:0]  check;
    logic [2:0]  bus_code;
    logic [15:0] tick_inc;
    logic [7:0]  row_inc;

    assign out_load = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg};

    assign bus_code = bus_to_code(in_req_reg.bus_status);
    assign tick_inc = tick_reg + 16'd1;
    assign row_inc  = (row_reg < 8'hFF) ? row_reg + 8'd1 : row_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg   <= DIVIDER_RST;
            max_fails_reg <= MAX_FAILS_RST;
            stale_reg     <= STALE_RST;
            address_reg   <= ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIVIDER:   divider_reg   <= cfg_data;
                CFG_MAX_FAILS: max_fails_reg <= cfg_data[7:0];
                CFG_STALE:     stale_reg     <= cfg_data;
                CFG_ADDRESS:   address_reg   <= cfg_data[6:0];
                default:       divider_reg   <= divider_reg;
            endcase
        end
    end

    // Work out the next state and the result of the held request
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        cached_next = cached_reg;
        age_next    = age_reg;
        held_next   = held_reg;
        last_next   = last_reg;
        cause_next  = cause_reg;
        total_next  = total_reg;
        row_next    = row_reg;
        status      = ST_OK;
        taken       = 1'b0;

        unique case (in_req_reg.command)
            CMD_TICK:
            begin
                if (phase_reg == PH_UNINIT)
                begin
                    last_next = ST_INIT;
                end
                else
                begin
                    if (age_reg < 16'hFFFF)
                    begin
                        age_next = age_reg + 16'd1;
                    end
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            if (tick_inc >= divider_reg)
                            begin
                                tick_next  = 16'd0;
                                phase_next = PH_READ;
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        PH_READ:
                        begin
                            taken = 1'b1;
                            if (bus_code == ST_OK)
                            begin
                                held_next  = in_req_reg.raw_word;
                                phase_next = PH_VALIDATE;
                            end
                            else
                            begin
                                // Count the failure and latch the fault on a long run
                                last_next = bus_code;
                                if (total_reg < 16'hFFFF)
                                begin
                                    total_next = total_reg + 16'd1;
                                end
                                row_next = row_inc;
                                if (row_inc >= max_fails_reg)
                                begin
                                    phase_next  = PH_FAULT;
                                    tick_next   = 16'd0;
                                    cause_next  = bus_code;
                                    cached_next = INVALID_TEMP;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        PH_VALIDATE:
                        begin
                            cached_next = convert_tenths(held_reg);
                            age_next    = 16'd0;
                            last_next   = ST_OK;
                            phase_next  = PH_IDLE;
                            row_next    = 8'd0;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                status = last_next;
            end
            CMD_RECOVER:
            begin
                if (phase_reg == PH_UNINIT)
                begin
                    status = ST_INIT;
                end
                else if (phase_reg == PH_FAULT)
                begin
                    row_next    = 8'd0;
                    tick_next   = 16'd0;
                    cached_next = INVALID_TEMP;
                    age_next    = 16'hFFFF;
                    phase_next  = PH_IDLE;
                end
            end
            CMD_INIT:
            begin
                // Clear the context, then check the address and bus readiness
                tick_next   = 16'd0;
                cached_next = INVALID_TEMP;
                age_next    = 16'd0;
                cause_next  = ST_OK;
                row_next    = 8'd0;
                if (address_reg < ADDR_LOW || address_reg > ADDR_HIGH)
                begin
                    status = ST_PARAM;
                end
                else
                begin
                    status = bus_code;
                end
                last_next = status;
                if (status == ST_OK)
                begin
                    phase_next = PH_IDLE;
                    total_next = 16'd0;
                end
                else
                begin
                    phase_next = PH_UNINIT;
                    total_next = 16'd1;
                end
            end
            default:
            begin
                status = ST_PARAM;
            end
        endcase

        if (cached_next == INVALID_TEMP)
        begin
            check = CHK_INVALID;
        end
        else if (age_next >= stale_reg)
        begin
            check = CHK_STALE;
        end
        else
        begin
            check = CHK_USABLE;
        end

        out_res_next.status             = status;
        out_res_next.read_taken         = taken;
        out_res_next.temperature_tenths = cached_next;
        out_res_next.temperature_check  = check;
        out_res_next.age                = age_next;
        out_res_next.total_faults       = total_next;
        out_res_next.latched_cause      = cause_next;
        out_res_next.recorded_status    = last_next;
        out_res_next.in_fault           = (phase_next == PH_FAULT);
    end

    // Hold or advance the input and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Capture request and result payloads
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg.command    <= s_tdata[1:0];
            in_req_reg.bus_status <= s_tdata[3:2];
            in_req_reg.raw_word   <= s_tdata[19:4];
        end
        if (advance)
        begin
            out_res_reg <= out_res_next;
        end
    end

    // Update supervisor state as each request retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_UNINIT;
            tick_reg   <= 16'd0;
            cached_reg <= INVALID_TEMP;
            age_reg    <= 16'd0;
            held_reg   <= 16'd0;
            last_reg   <= ST_INIT;
            cause_reg  <= ST_OK;
            total_reg  <= 16'd0;
            row_reg    <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            cached_reg <= cached_next;
            age_reg    <= age_next;
            held_reg   <= held_next;
            last_reg   <= last_next;
            cause_reg  <= cause_next;
            total_reg  <= total_next;
            row_reg    <= row_next;
        end
    end

endmodule

>>> tb/tb_temp_sensor_acquisition_supervisor_top.sv
`timescale 1ns / 1ps

module tb_temp_sensor_acquisition_supervisor_top;
    import tsas_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [1:0] BUS_ERROR    = 2'd2;
    localparam logic [1:0] BUS_RESERVED = 2'd3;

    localparam int MAX_GAP       = 18;
    localparam int LONG_HOLD     = 90;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_ITEMS   = 150;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [1:0]  cmd;
        logic [1:0]  bus;
        logic [15:0] raw;
        bit          typed;
        result_t     want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = CFG_DIVIDER;
    logic [15:0]           cfg_data = '0;

    // Supervisor state as the block should hold it
    logic [2:0]         cur_phase;
    logic [15:0]        div_count;
    logic signed [15:0] cached_tenths;
    logic [15:0]        ticks_since_sample;
    logic [15:0]        held_word;
    logic [2:0]         recorded_code;
    logic [2:0]         fault_reason;
    logic [15:0]        failure_total;
    logic [7:0]         run_of_failures;

    // Register copies
    logic [15:0] set_divider;
    logic [7:0]  set_fail_limit;
    logic [15:0] set_stale_limit;
    logic [6:0]  set_address;

    result_t    pending_results[$];
    dir_row_t   directed_rows[$];
    result_t    seen_result;
    result_t    wanted_result;
    int         mismatch_count = 0;
    int         results_seen = 0;
    bit         steady_flow = 1'b0;

    temp_sensor_acquisition_supervisor_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Supervisor prediction
    // ---------------------------------------------------------------

    function automatic logic [2:0] status_of_bus(input logic [1:0] bus);
        logic [2:0] code;
        if (bus == BUS_OK)
        begin
            code = ST_OK;
        end
        else if (bus == BUS_TIMEOUT)
        begin
            code = ST_TIMEOUT;
        end
        else
        begin
            code = ST_BUS;
        end
        return code;
    endfunction

    // Q4 reading in bits 12..0 to tenths, halves rounded away from zero
    function automatic logic signed [15:0] tenths_of(input logic [15:0] word);
        int reading;
        int scaled;
        reading = int'(word[12:0]);
        if (word[12])
        begin
            reading = reading - 8192;
        end
        if (reading < 0)
        begin
            scaled = -((-reading * 10 + 8) / 16);
        end
        else
        begin
            scaled = (reading * 10 + 8) / 16;
        end
        return scaled[15:0];
    endfunction

    function automatic void clear_supervision();
        cur_phase          = PH_UNINIT;
        div_count          = '0;
        cached_tenths      = INVALID_TEMP;
        ticks_since_sample = '0;
        recorded_code      = ST_INIT;
        fault_reason       = ST_OK;
        failure_total      = '0;
        run_of_failures    = '0;
    endfunction

    // Count a failed read and latch the fault once the run is long enough
    function automatic void note_failure(input logic [2:0] code);
        recorded_code = code;
        if (failure_total != 16'hFFFF)
        begin
            failure_total = failure_total + 16'd1;
        end
        if (run_of_failures != 8'hFF)
        begin
            run_of_failures = run_of_failures + 8'd1;
        end
        if (run_of_failures >= set_fail_limit)
        begin
            cur_phase     = PH_FAULT;
            div_count     = '0;
            fault_reason  = code;
            cached_tenths = INVALID_TEMP;
        end
        else
        begin
            cur_phase = PH_IDLE;
        end
    endfunction

    function automatic result_t supervise_step(input logic [1:0] cmd, input logic [1:0] bus,
                                               input logic [15:0] raw);
        result_t    r;
        logic [2:0] code;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_TICK:
            begin
                if (cur_phase == PH_UNINIT)
                begin
                    recorded_code = ST_INIT;
                end
                else
                begin
                    if (ticks_since_sample != 16'hFFFF)
                    begin
                        ticks_since_sample = ticks_since_sample + 16'd1;
                    end
                    case (cur_phase)
                        PH_IDLE:
                        begin
                            div_count = div_count + 16'd1;
                            if (div_count >= set_divider)
                            begin
                                div_count = '0;
                                cur_phase = PH_READ;
                            end
                        end
                        PH_READ:
                        begin
                            code = status_of_bus(bus);
                            r.read_taken = 1'b1;
                            if (code == ST_OK)
                            begin
                                held_word = raw;
                                cur_phase = PH_VALIDATE;
                            end
                            else
                            begin
                                note_failure(code);
                            end
                        end
                        PH_VALIDATE:
                        begin
                            cached_tenths      = tenths_of(held_word);
                            ticks_since_sample = '0;
                            recorded_code      = ST_OK;
                            cur_phase          = PH_IDLE;
                            run_of_failures    = '0;
                        end
                        default:
                        begin
                            // fault: only the age moves
                        end
                    endcase
                end
                r.status = recorded_code;
            end
            CMD_RECOVER:
            begin
                if (cur_phase == PH_UNINIT)
                begin
                    r.status = ST_INIT;
                end
                else if (cur_phase == PH_FAULT)
                begin
                    run_of_failures    = '0;
                    div_count          = '0;
                    cached_tenths      = INVALID_TEMP;
                    ticks_since_sample = 16'hFFFF;
                    cur_phase          = PH_IDLE;
                end
            end
            CMD_INIT:
            begin
                clear_supervision();
                if (set_address < ADDR_LOW || set_address > ADDR_HIGH)
                begin
                    code = ST_PARAM;
                end
                else
                begin
                    code = status_of_bus(bus);
                end
                recorded_code = code;
                r.status = code;
                if (code == ST_OK)
                begin
                    cur_phase = PH_IDLE;
                end
                else
                begin
                    failure_total = 16'd1;
                end
            end
            default:
            begin
                r.status = ST_PARAM;
            end
        endcase

        if (cached_tenths == INVALID_TEMP)
        begin
            r.temperature_check = CHK_INVALID;
        end
        else if (ticks_since_sample >= set_stale_limit)
        begin
            r.temperature_check = CHK_STALE;
        end
        else
        begin
            r.temperature_check = CHK_USABLE;
        end
        r.temperature_tenths = cached_tenths;
        r.age                = ticks_since_sample;
        r.total_faults       = failure_total;
        r.latched_cause      = fault_reason;
        r.recorded_status    = recorded_code;
        r.in_fault           = (cur_phase == PH_FAULT);
        return r;
    endfunction

    // Result of a step that leaves the supervisor out of fault with nothing cached
    function automatic result_t cleared_result(input logic [2:0] status,
                                               input logic [2:0] recorded,
                                               input logic [15:0] faults);
        result_t r;
        r = '0;
        r.status             = status;
        r.temperature_tenths = INVALID_TEMP;
        r.temperature_check  = CHK_INVALID;
        r.total_faults       = faults;
        r.latched_cause      = ST_OK;
        r.recorded_status    = recorded;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    task automatic load_settings(input logic [15:0] divider, input logic [15:0] fail_limit,
                                 input logic [15:0] stale, input logic [15:0] address);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DIVIDER;
        cfg_data  <= divider;
        @(posedge clk);
        cfg_index <= CFG_MAX_FAILS;
        cfg_data  <= fail_limit;
        @(posedge clk);
        cfg_index <= CFG_STALE;
        cfg_data  <= stale;
        @(posedge clk);
        cfg_index <= CFG_ADDRESS;
        cfg_data  <= address;
        @(posedge clk);
        cfg_we    <= 1'b0;
        set_divider     = divider;
        set_fail_limit  = fail_limit[7:0];
        set_stale_limit = stale;
        set_address     = address[6:0];
    endtask

    // Offer one request; keep valid high afterwards unless the next one waits
    task automatic send_request(input logic [1:0] cmd, input logic [1:0] bus,
                                input logic [15:0] raw, input bit typed,
                                input result_t typed_result);
        int      gap;
        result_t predicted;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, raw, bus, cmd};
        do @(posedge clk); while (!s_tready);
        predicted = supervise_step(cmd, bus, raw);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Drain the block before touching the registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns, result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.status             = m_tdata[2:0];
            seen_result.read_taken         = m_tdata[3];
            seen_result.temperature_tenths = m_tdata[19:4];
            seen_result.temperature_check  = m_tdata[21:20];
            seen_result.age                = m_tdata[37:22];
            seen_result.total_faults       = m_tdata[53:38];
            seen_result.latched_cause      = m_tdata[56:54];
            seen_result.recorded_status    = m_tdata[59:57];
            seen_result.in_fault           = m_tdata[60];
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing expected");
            end
            else
            begin
                wanted_result = pending_results.pop_front();
                check_field("status", 16'(seen_result.status), 16'(wanted_result.status));
                check_field("read_taken", 16'(seen_result.read_taken),
                            16'(wanted_result.read_taken));
                check_field("temperature_tenths", seen_result.temperature_tenths,
                            wanted_result.temperature_tenths);
                check_field("temperature_check", 16'(seen_result.temperature_check),
                            16'(wanted_result.temperature_check));
                check_field("age", seen_result.age, wanted_result.age);
                check_field("total_faults", seen_result.total_faults,
                            wanted_result.total_faults);
                check_field("latched_cause", 16'(seen_result.latched_cause),
                            16'(wanted_result.latched_cause));
                check_field("recorded_status", 16'(seen_result.recorded_status),
                            16'(wanted_result.recorded_status));
                check_field("in_fault", 16'(seen_result.in_fault),
                            16'(wanted_result.in_fault));
            end
            results_seen++;
        end
    end

    // Accept results with random stalls, and hold off twice for a long stretch
    initial
    begin : result_sink
        int wait_cycles;
        int taken;
        taken = 0;
        forever
        begin
            if (taken == 400 || taken == 1000)
            begin
                wait_cycles = LONG_HOLD;
            end
            else
            begin
                wait_cycles = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    // Stop a run that hangs
    initial
    begin : watchdog
        int unsigned cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        logic [15:0] fixed_divider[4];
        logic [15:0] fixed_fail_limit[4];
        logic [15:0] fixed_stale[4];
        logic [15:0] fixed_address[4];
        logic [15:0] divider;
        logic [15:0] fail_limit;
        logic [15:0] stale;
        logic [15:0] address;
        logic [1:0]  cmd;
        logic [1:0]  bus;
        int          pick;

        fixed_divider    = '{16'd0, 16'd65535, 16'd2, 16'd1};
        fixed_fail_limit = '{16'd1, 16'd255, 16'd0, 16'd3};
        fixed_stale      = '{16'd0, 16'd65535, 16'd5, 16'd10};
        fixed_address    = '{16'd24, 16'd31, 16'd28, 16'd127};

        clear_supervision();
        held_word       = '0;
        set_divider     = DIVIDER_RST;
        set_fail_limit  = MAX_FAILS_RST;
        set_stale_limit = STALE_RST;
        set_address     = ADDRESS_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short divider and failure limit so the directed rows reach every phase
        load_settings(16'd0, 16'd2, 16'd3, 16'd31);

        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b1,
                                  cleared_result(ST_INIT, ST_INIT, 16'd0)});
        directed_rows.push_back('{CMD_RECOVER, BUS_OK, 16'h0000, 1'b1,
                                  cleared_result(ST_INIT, ST_INIT, 16'd0)});
        directed_rows.push_back('{CMD_RESERVED, BUS_OK, 16'hFFFF, 1'b1,
                                  cleared_result(ST_PARAM, ST_INIT, 16'd0)});
        directed_rows.push_back('{CMD_INIT, BUS_TIMEOUT, 16'h0000, 1'b1,
                                  cleared_result(ST_TIMEOUT, ST_TIMEOUT, 16'd1)});
        directed_rows.push_back('{CMD_INIT, BUS_RESERVED, 16'h0000, 1'b1,
                                  cleared_result(ST_BUS, ST_BUS, 16'd1)});
        directed_rows.push_back('{CMD_INIT, BUS_OK, 16'h0000, 1'b1,
                                  cleared_result(ST_OK, ST_OK, 16'd0)});
        // Hottest reading, then coldest with the alert flags set, then just below zero
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0FFF, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'hF000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'hFFFF, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        // Two failed reads in a row latch the fault
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_TIMEOUT, 16'h1234, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_ERROR, 16'h5678, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_RECOVER, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_RECOVER, BUS_OK, 16'h0000, 1'b0, '0});
        // Half a degree converts to five tenths
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0008, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, BUS_OK, 16'h0000, 1'b0, '0});

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].cmd, directed_rows[i].bus, directed_rows[i].raw,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, each under its own register settings
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            if (p < 4)
            begin
                divider    = fixed_divider[p];
                fail_limit = fixed_fail_limit[p];
                stale      = fixed_stale[p];
                address    = fixed_address[p];
            end
            else
            begin
                divider    = 16'($urandom_range(0, 5));
                fail_limit = 16'($urandom_range(1, 4));
                stale      = 16'($urandom_range(0, 30));
                if (p == 5)
                begin
                    // upper bits beyond the register are dropped
                    address = 16'hFF98;
                end
                else if (p == 7)
                begin
                    address = 16'd32;
                end
                else
                begin
                    address = 16'($urandom_range(24, 31));
                end
            end
            load_settings(divider, fail_limit, stale, address);
            steady_flow = (p % 3 == 2);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 82)
                begin
                    cmd = CMD_TICK;
                end
                else if (pick < 90)
                begin
                    cmd = CMD_RECOVER;
                end
                else if (pick < 97)
                begin
                    cmd = CMD_INIT;
                end
                else
                begin
                    cmd = CMD_RESERVED;
                end
                if ($urandom_range(0, 99) < 75)
                begin
                    bus = BUS_OK;
                end
                else
                begin
                    bus = 2'($urandom_range(1, 3));
                end
                send_request(cmd, bus, 16'($urandom_range(0, 65535)), 1'b0, '0);
            end
        end

        settle();
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> temp_sensor_acquisition_supervisor_top.f
hw/rtl/tsas_pkg.sv
hw/rtl/temp_sensor_acquisition_supervisor_top.sv
tb/tb_temp_sensor_acquisition_supervisor_top.sv
